### rtl/bsc_pkg.sv
// Shared types, constants and arithmetic helpers of the barometric compensation block.
package bsc_pkg;

  localparam int unsigned DivBits = 32;

  localparam logic signed [31:0] FineOffset = 32'sd64000;
  localparam logic signed [31:0] PressBase  = 32'sd32768;
  localparam logic signed [31:0] TempRound  = 32'sd128;
  localparam logic [31:0]        RawFull    = 32'd1048576;
  localparam logic [31:0]        PressScale = 32'd3125;

  localparam logic [1:0] RegTempCal   = 2'd0;
  localparam logic [1:0] RegPressCal1 = 2'd1;
  localparam logic [1:0] RegPressCal2 = 2'd2;
  localparam logic [1:0] RegPressCal9 = 2'd3;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_pa;
    logic               pressure_invalid;
  } out_item_t;

  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } cal_t;

  typedef struct packed {
    logic [31:0]        dividend;
    logic [31:0]        den;
    logic               mode;
    logic               invalid;
    logic signed [15:0] temp;
  } div_in_t;

  typedef struct packed {
    logic [31:0]        quo;
    logic               mode;
    logic               invalid;
    logic signed [15:0] temp;
  } div_out_t;

  function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[31:0];
  endfunction

  function automatic logic signed [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic signed [31:0] zext16(input logic [15:0] v);
    return {16'd0, v};
  endfunction

endpackage

### rtl/bsc_regs.sv
// Calibration register file behind the APB-style configuration port.
module bsc_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready,
  output bsc_pkg::cal_t      cal_o
);

  logic [47:0] temp_cal_q;
  logic [63:0] press1_q;
  logic [63:0] press2_q;
  logic [15:0] press9_q;
  logic        wr_en;
  logic [1:0]  idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:3];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q <= '0;
      press1_q   <= '0;
      press2_q   <= '0;
      press9_q   <= '0;
    end else if (wr_en) begin
      case (idx)
        bsc_pkg::RegTempCal:   temp_cal_q <= pwdata[47:0];
        bsc_pkg::RegPressCal1: press1_q   <= pwdata;
        bsc_pkg::RegPressCal2: press2_q   <= pwdata;
        bsc_pkg::RegPressCal9: press9_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bsc_pkg::RegTempCal:   prdata = {16'd0, temp_cal_q};
      bsc_pkg::RegPressCal1: prdata = press1_q;
      bsc_pkg::RegPressCal2: prdata = press2_q;
      bsc_pkg::RegPressCal9: prdata = {48'd0, press9_q};
      default:               prdata = '0;
    endcase
  end

  assign cal_o.t1 = temp_cal_q[15:0];
  assign cal_o.t2 = temp_cal_q[31:16];
  assign cal_o.t3 = temp_cal_q[47:32];
  assign cal_o.p1 = press1_q[15:0];
  assign cal_o.p2 = press1_q[31:16];
  assign cal_o.p3 = press1_q[47:32];
  assign cal_o.p4 = press1_q[63:48];
  assign cal_o.p5 = press2_q[15:0];
  assign cal_o.p6 = press2_q[31:16];
  assign cal_o.p7 = press2_q[47:32];
  assign cal_o.p8 = press2_q[63:48];
  assign cal_o.p9 = press9_q;

endmodule

### rtl/bsc_front.sv
// Temperature compensation and pressure numerator/divisor pipeline.
module bsc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsc_pkg::cal_t      cal_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsc_pkg::in_item_t  in_data_i,
  output logic               dv_valid_o,
  input  logic               dv_ready_i,
  output bsc_pkg::div_in_t   dv_data_o
);

  logic [6:0] v_q;
  logic [6:0] rdy;

  logic signed [31:0] adc_t, t1s, x1, d1;
  logic signed [31:0] s1_a_q, s1_dd_q;
  logic [19:0]        s1_p_q, s2_p_q, s3_p_q, s4_p_q, s5_p_q;
  logic signed [31:0] s2_fine_q;
  logic signed [31:0] tt;
  logic signed [15:0] tsat;
  logic signed [15:0] s3_t_q, s4_t_q, s5_t_q, s6_t_q;
  logic signed [31:0] s3_a_q, a4;
  logic signed [31:0] s4_sq_q, s4_m5_q, s4_m2_q;
  logic signed [31:0] b5, a5;
  logic signed [31:0] s5_b_q, s5_a_q;
  logic signed [31:0] s6_x_q, dv;
  logic [31:0]        num6, s6_n_q;
  bsc_pkg::div_in_t   s7_q;

  assign rdy[6] = ~v_q[6] | dv_ready_i;
  for (genvar k = 0; k < 6; k++) begin : g_rdy
    assign rdy[k] = ~v_q[k] | rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < 7; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign adc_t = {12'd0, in_data_i.raw_temperature};
  assign t1s   = bsc_pkg::zext16(cal_i.t1);
  assign x1    = (adc_t >>> 3) - (t1s <<< 1);
  assign d1    = (adc_t >>> 4) - t1s;

  always_comb begin
    tt = (bsc_pkg::mul32(s2_fine_q, 32'sd5) + bsc_pkg::TempRound) >>> 8;
    if (tt > 32'sd32767)       tsat = 16'sh7fff;
    else if (tt < -32'sd32768) tsat = 16'sh8000;
    else                       tsat = tt[15:0];
  end

  assign a4 = s3_a_q >>> 2;

  always_comb begin
    b5 = bsc_pkg::mul32(s4_sq_q >>> 11, bsc_pkg::sext16(cal_i.p6)) + (s4_m5_q <<< 1);
    b5 = (b5 >>> 2) + (bsc_pkg::sext16(cal_i.p4) <<< 16);
    a5 = ((bsc_pkg::mul32(bsc_pkg::sext16(cal_i.p3), s4_sq_q >>> 13) >>> 3)
          + (s4_m2_q >>> 1)) >>> 18;
  end

  assign num6 = ((bsc_pkg::RawFull - {12'd0, s5_p_q}) - 32'(s5_b_q >>> 12))
                * bsc_pkg::PressScale;
  assign dv   = s6_x_q >>> 15;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_a_q  <= bsc_pkg::mul32(x1, bsc_pkg::sext16(cal_i.t2)) >>> 11;
      s1_dd_q <= bsc_pkg::mul32(d1, d1);
      s1_p_q  <= in_data_i.raw_pressure;
    end
    if (rdy[1]) begin
      s2_fine_q <= s1_a_q
                 + (bsc_pkg::mul32(s1_dd_q >>> 12, bsc_pkg::sext16(cal_i.t3)) >>> 14);
      s2_p_q    <= s1_p_q;
    end
    if (rdy[2]) begin
      s3_t_q <= tsat;
      s3_a_q <= (s2_fine_q >>> 1) - bsc_pkg::FineOffset;
      s3_p_q <= s2_p_q;
    end
    if (rdy[3]) begin
      s4_sq_q <= bsc_pkg::mul32(a4, a4);
      s4_m5_q <= bsc_pkg::mul32(s3_a_q, bsc_pkg::sext16(cal_i.p5));
      s4_m2_q <= bsc_pkg::mul32(bsc_pkg::sext16(cal_i.p2), s3_a_q);
      s4_t_q  <= s3_t_q;
      s4_p_q  <= s3_p_q;
    end
    if (rdy[4]) begin
      s5_b_q <= b5;
      s5_a_q <= a5;
      s5_t_q <= s4_t_q;
      s5_p_q <= s4_p_q;
    end
    if (rdy[5]) begin
      s6_x_q <= bsc_pkg::mul32(bsc_pkg::PressBase + s5_a_q, bsc_pkg::zext16(cal_i.p1));
      s6_n_q <= num6;
      s6_t_q <= s5_t_q;
    end
    if (rdy[6]) begin
      s7_q.den      <= dv;
      s7_q.invalid  <= (dv == 32'sd0);
      s7_q.mode     <= s6_n_q[31];
      s7_q.dividend <= s6_n_q[31] ? s6_n_q : {s6_n_q[30:0], 1'b0};
      s7_q.temp     <= s6_t_q;
    end
  end

  assign dv_valid_o = v_q[6];
  assign dv_data_o  = s7_q;

endmodule

### rtl/bsc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module bsc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsc_pkg::div_in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsc_pkg::div_out_t  out_data_o
);

  typedef struct packed {
    logic [31:0]        num;
    logic [31:0]        quo;
    logic [31:0]        rem;
    logic [31:0]        den;
    logic               mode;
    logic               invalid;
    logic signed [15:0] temp;
  } div_stage_t;

  logic [bsc_pkg::DivBits-1:0] v_q;
  logic [bsc_pkg::DivBits-1:0] v_src;
  logic [bsc_pkg::DivBits-1:0] rdy;
  div_stage_t                  st_q [bsc_pkg::DivBits];
  div_stage_t                  src  [bsc_pkg::DivBits];
  div_stage_t                  nxt  [bsc_pkg::DivBits];
  div_stage_t                  head;

  assign head.num     = in_data_i.dividend;
  assign head.quo     = '0;
  assign head.rem     = '0;
  assign head.den     = in_data_i.den;
  assign head.mode    = in_data_i.mode;
  assign head.invalid = in_data_i.invalid;
  assign head.temp    = in_data_i.temp;

  assign rdy[bsc_pkg::DivBits-1] = ~v_q[bsc_pkg::DivBits-1] | out_ready_i;

  for (genvar i = 0; i < bsc_pkg::DivBits; i++) begin : g_stage
    logic [32:0] trial;
    logic        ge;

    if (i == 0) begin : g_head
      assign src[i]   = head;
      assign v_src[i] = in_valid_i;
    end else begin : g_link
      assign src[i]   = st_q[i-1];
      assign v_src[i] = v_q[i-1];
    end
    if (i < bsc_pkg::DivBits - 1) begin : g_rdy
      assign rdy[i] = ~v_q[i] | rdy[i+1];
    end

    assign trial = {src[i].rem, src[i].num[31]};
    assign ge    = trial >= {1'b0, src[i].den};

    always_comb begin
      nxt[i]     = src[i];
      nxt[i].num = {src[i].num[30:0], 1'b0};
      nxt[i].quo = {src[i].quo[30:0], ge};
      nxt[i].rem = ge ? 32'(trial - {1'b0, src[i].den}) : trial[31:0];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= v_src[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i]) st_q[i] <= nxt[i];
    end
  end

  assign in_ready_o          = rdy[0];
  assign out_valid_o         = v_q[bsc_pkg::DivBits-1];
  assign out_data_o.quo      = st_q[bsc_pkg::DivBits-1].quo;
  assign out_data_o.mode     = st_q[bsc_pkg::DivBits-1].mode;
  assign out_data_o.invalid  = st_q[bsc_pkg::DivBits-1].invalid;
  assign out_data_o.temp     = st_q[bsc_pkg::DivBits-1].temp;

`ifndef SYNTHESIS
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !st_q[0].invalid |-> st_q[0].rem < st_q[0].den)
    else $error("divider remainder not below divisor");
  a_last_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !st_q[bsc_pkg::DivBits-1].invalid
    |-> st_q[bsc_pkg::DivBits-1].rem < st_q[bsc_pkg::DivBits-1].den)
    else $error("final remainder not below divisor");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o.quo))
    else $error("stalled quotient lost");
`endif

endmodule

### rtl/bsc_back.sv
// Final pressure correction stages and output register.
module bsc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bsc_pkg::cal_t      cal_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bsc_pkg::div_out_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bsc_pkg::out_item_t out_data_o
);

  logic [2:0]         v_q;
  logic [2:0]         rdy;
  logic [31:0]        p0, p0s;
  logic [31:0]        b1_p_q, b1_sq_q, b2_p_q;
  logic signed [31:0] b1_m_q, b2_a_q, b2_b_q, corr;
  logic               b1_inv_q, b2_inv_q;
  logic signed [15:0] b1_t_q, b2_t_q;
  bsc_pkg::out_item_t out_q;

  assign rdy[2] = ~v_q[2] | out_ready_i;
  assign rdy[1] = ~v_q[1] | rdy[2];
  assign rdy[0] = ~v_q[0] | rdy[1];
  assign in_ready_o = rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= in_valid_i;
      if (rdy[1]) v_q[1] <= v_q[0];
      if (rdy[2]) v_q[2] <= v_q[1];
    end
  end

  assign p0   = in_data_i.mode ? {in_data_i.quo[30:0], 1'b0} : in_data_i.quo;
  assign p0s  = p0 >> 3;
  assign corr = (b2_a_q + b2_b_q + bsc_pkg::sext16(cal_i.p7)) >>> 4;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      b1_p_q   <= p0;
      b1_sq_q  <= 32'(p0s * p0s);
      b1_m_q   <= bsc_pkg::mul32({2'b00, p0[31:2]}, bsc_pkg::sext16(cal_i.p8));
      b1_inv_q <= in_data_i.invalid;
      b1_t_q   <= in_data_i.temp;
    end
    if (rdy[1]) begin
      b2_a_q   <= bsc_pkg::mul32(bsc_pkg::sext16(cal_i.p9), {13'd0, b1_sq_q[31:13]}) >>> 12;
      b2_b_q   <= b1_m_q >>> 13;
      b2_p_q   <= b1_p_q;
      b2_inv_q <= b1_inv_q;
      b2_t_q   <= b1_t_q;
    end
    if (rdy[2]) begin
      out_q.temperature_centi <= b2_t_q;
      out_q.pressure_pa       <= b2_inv_q ? 32'd0 : b2_p_q + 32'(corr);
      out_q.pressure_invalid  <= b2_inv_q;
    end
  end

  assign out_valid_o = v_q[2];
  assign out_data_o  = out_q;

endmodule

### rtl/baro_sensor_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
// Input channel: in_valid_i/in_ready_o carry one raw temperature and pressure
// pair per transaction. Output channel: out_valid_o/out_ready_i carry the
// temperature in hundredths of a degree, pressure in pascals and an invalid
// flag set when the pressure divisor is zero (pressure then reads 0).
// The user must write calibration words over the APB-style port at byte
// addresses 0, 8, 16 and 24 only while no transaction is in flight; the
// block does not enforce this. Stages: 7 of temperature and divisor
// arithmetic, 32 of the bit-per-stage pressure divider and 3 correction
// stages ending in the output register. One transaction is taken every
// cycle unless stalled. Reset clears the calibration registers and every
// stage valid bit. On a receiver stall, a stage holds while all later stages
// are full; empty stages still fill, so up to 42 transactions are held.
module baro_sensor_compensation (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bsc_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bsc_pkg::out_item_t  out_data_o
);

  bsc_pkg::cal_t     cal;
  bsc_pkg::div_in_t  dv_in;
  bsc_pkg::div_out_t dv_out;
  logic              dv_in_valid, dv_in_ready, dv_out_valid, dv_out_ready;

  bsc_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cal_o(cal)
  );

  bsc_front u_front (
    .clk_i, .rst_ni, .cal_i(cal),
    .in_valid_i, .in_ready_o, .in_data_i,
    .dv_valid_o(dv_in_valid), .dv_ready_i(dv_in_ready), .dv_data_o(dv_in)
  );

  bsc_div u_div (
    .clk_i, .rst_ni,
    .in_valid_i(dv_in_valid), .in_ready_o(dv_in_ready), .in_data_i(dv_in),
    .out_valid_o(dv_out_valid), .out_ready_i(dv_out_ready), .out_data_o(dv_out)
  );

  bsc_back u_back (
    .clk_i, .rst_ni, .cal_i(cal),
    .in_valid_i(dv_out_valid), .in_ready_o(dv_out_ready), .in_data_i(dv_out),
    .out_valid_o, .out_ready_i, .out_data_o
  );

endmodule
